// ===== hdl/ffe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffe_pkg: shared types and constants of the Fourier forcing evaluator
// Command codes, register indexes, micro-operation codes and the
// quarter-wave sine polynomial.
// ----------------------------------------------------------------------------
package ffe_pkg;

    localparam int MAX_MODES_DEF = 256;
    localparam int TRIG_BITS_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_D     = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [3:0] WSEL_K_X   = 4'd0;
    localparam logic [3:0] WSEL_K_Z   = 4'd2;
    localparam logic [3:0] WSEL_AMP   = 4'd3;
    localparam logic [3:0] WSEL_COS_X = 4'd4;
    localparam logic [3:0] WSEL_COS_Z = 4'd6;
    localparam logic [3:0] WSEL_SIN_X = 4'd7;
    localparam logic [3:0] WSEL_SIN_Z = 4'd9;

    localparam int FETCH_WORDS = 10;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_KX,
        MUL_KY,
        MUL_KZ,
        MUL_TT,
        MUL_PT2,
        MUL_PT,
        MUL_AC,
        MUL_BS,
        MUL_AI,
        MUL_SLO,
        MUL_SHI
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_PH_CLR,
        WB_PH_ADD,
        WB_T2,
        WB_HORN,
        WB_FIN,
        WB_AC,
        WB_BS,
        WB_ACC,
        WB_SLO,
        WB_SHI
    } wb_op_t;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       fetch;
        logic [3:0] fetch_word;
        mul_op_t    mul;
        wb_op_t     wb;
        logic [1:0] axis;
        logic       cos_pass;
        logic [2:0] horn_idx;
    } dp_cmd_t;

    // Q30 coefficients of the odd polynomial for sin(pi/2 t)
    function automatic logic [31:0] sin_poly(input logic [2:0] i);
        logic [31:0] c;
        begin
            case (i)
                3'd0:    c = 32'd1686629713;
                3'd1:    c = 32'd693598668;
                3'd2:    c = 32'd85569306;
                3'd3:    c = 32'd5026995;
                3'd4:    c = 32'd172272;
                3'd5:    c = 32'd3864;
                3'd6:    c = 32'd61;
                default: c = 32'd0;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ffe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffe_ctrl: sequencer of the Fourier forcing evaluator
// Walks the fetch, per-mode micro-program and final scaling steps, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ffe_ctrl #(
    parameter int MAX_MODES = ffe_pkg::MAX_MODES_DEF,
    localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1,
    localparam int CNT_W = $clog2(MAX_MODES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             cmd_bit,
    input  wire logic [CNT_W-1:0] n_modes,
    output logic [IDX_W-1:0]      mode_idx,
    output ffe_pkg::dp_cmd_t      cmd,
    output logic                  m_tvalid,
    input  wire logic             m_tready
);
    import ffe_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_CALC  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_SCALE = 5'b10000
    } state_t;

    localparam logic [5:0] FETCH_LAST = 6'(FETCH_WORDS);
    localparam logic [5:0] CALC_LAST  = 6'd55;
    localparam logic [5:0] SCALE_LAST = 6'd11;

    state_t           state_reg, state_next;
    logic [5:0]       step_reg, step_next;
    logic [CNT_W-1:0] mode_reg, mode_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    logic [4:0]       pair;
    logic [CNT_W-1:0] mode_inc;
    mul_op_t          mul_sel;
    wb_op_t           wb_sel;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign mode_idx = mode_reg[IDX_W-1:0];
    assign mode_inc = mode_reg + CNT_W'(1);
    assign pair     = step_reg[5:1];

    // micro-program: even cycle multiplies, odd cycle writes the product back
    always_comb
    begin
        cmd            = '0;
        cmd.mul        = MUL_NONE;
        cmd.wb         = WB_NONE;
        cmd.fetch_word = step_reg[3:0];
        mul_sel        = MUL_NONE;
        wb_sel         = WB_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = accept & (cmd_bit == CMD_EVAL);
                cmd.load    = accept & (cmd_bit == CMD_LOAD);
            end
            ST_FETCH:
            begin
                cmd.fetch = (step_reg < FETCH_LAST);
            end
            ST_CALC:
            begin
                cmd.cos_pass = (pair >= 5'd11);
                cmd.horn_idx = (pair <= 5'd9) ? 3'(5'd9 - pair) : 3'(5'd17 - pair);
                if (pair >= 5'd25)
                    cmd.axis = 2'd2;
                else if (pair >= 5'd22)
                    cmd.axis = 2'd1;
                else
                    cmd.axis = 2'd0;
                unique case (pair) inside
                    5'd0:
                    begin
                        mul_sel = MUL_KX;
                        wb_sel  = WB_PH_CLR;
                    end
                    5'd1:
                    begin
                        mul_sel = MUL_KY;
                        wb_sel  = WB_PH_ADD;
                    end
                    5'd2:
                    begin
                        mul_sel = MUL_KZ;
                        wb_sel  = WB_PH_ADD;
                    end
                    5'd3, 5'd11:
                    begin
                        mul_sel = MUL_TT;
                        wb_sel  = WB_T2;
                    end
                    [5'd4:5'd9], [5'd12:5'd17]:
                    begin
                        mul_sel = MUL_PT2;
                        wb_sel  = WB_HORN;
                    end
                    5'd10, 5'd18:
                    begin
                        mul_sel = MUL_PT;
                        wb_sel  = WB_FIN;
                    end
                    5'd19, 5'd22, 5'd25:
                    begin
                        mul_sel = MUL_AC;
                        wb_sel  = WB_AC;
                    end
                    5'd20, 5'd23, 5'd26:
                    begin
                        mul_sel = MUL_BS;
                        wb_sel  = WB_BS;
                    end
                    5'd21, 5'd24, 5'd27:
                    begin
                        mul_sel = MUL_AI;
                        wb_sel  = WB_ACC;
                    end
                    default:
                    begin
                        mul_sel = MUL_NONE;
                        wb_sel  = WB_NONE;
                    end
                endcase
                cmd.mul = step_reg[0] ? MUL_NONE : mul_sel;
                cmd.wb  = step_reg[0] ? wb_sel : WB_NONE;
            end
            ST_WAIT:
            begin
                cmd.mul = MUL_NONE;
            end
            ST_SCALE:
            begin
                cmd.axis = (pair >= 5'd4) ? 2'd2 : ((pair >= 5'd2) ? 2'd1 : 2'd0);
                mul_sel  = pair[0] ? MUL_SHI : MUL_SLO;
                wb_sel   = pair[0] ? WB_SHI : WB_SLO;
                cmd.mul  = step_reg[0] ? MUL_NONE : mul_sel;
                cmd.wb   = step_reg[0] ? wb_sel : WB_NONE;
            end
            default:
            begin
                cmd.mul = MUL_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                mode_next = '0;
                if (accept && (cmd_bit == CMD_EVAL))
                    state_next = (n_modes == '0) ? ST_WAIT : ST_FETCH;
            end
            ST_FETCH:
            begin
                if (step_reg == FETCH_LAST)
                begin
                    state_next = ST_CALC;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + 6'd1;
            end
            ST_CALC:
            begin
                if (step_reg == CALC_LAST)
                begin
                    step_next = '0;
                    if (mode_inc == n_modes)
                        state_next = ST_WAIT;
                    else
                    begin
                        mode_next  = mode_inc;
                        state_next = ST_FETCH;
                    end
                end
                else
                    step_next = step_reg + 6'd1;
            end
            ST_WAIT:
            begin
                // hold until the previous result has been taken
                step_next = '0;
                if (!out_valid_reg)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (step_reg == SCALE_LAST)
                begin
                    state_next     = ST_IDLE;
                    step_next      = '0;
                    out_valid_next = 1'b1;
                end
                else
                    step_next = step_reg + 6'd1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ffe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffe_datapath: mode table, shared multiplier and accumulators
// Holds the configuration registers and the mode table memory, and runs
// the phase, sine polynomial, per-axis sums and final scaling.
// ----------------------------------------------------------------------------
module ffe_datapath #(
    parameter int MAX_MODES = ffe_pkg::MAX_MODES_DEF,
    parameter int TRIG_BITS = ffe_pkg::TRIG_BITS_DEF,
    localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1,
    localparam int CNT_W = $clog2(MAX_MODES + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ffe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [ffe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [7:0]                      mode_slot,
    input  wire logic [3:0]                      word_select,
    input  wire logic [31:0]                     word_value,
    input  wire logic [31:0]                     pos_x,
    input  wire logic [31:0]                     pos_y,
    input  wire logic [31:0]                     pos_z,
    input  wire logic                            has_mass,
    input  wire ffe_pkg::dp_cmd_t                cmd,
    input  wire logic [IDX_W-1:0]                mode_idx,
    output logic [CNT_W-1:0]                     n_modes,
    output logic [31:0]                          accel_x,
    output logic [31:0]                          accel_y,
    output logic [31:0]                          accel_z
);
    import ffe_pkg::*;

    localparam int FRAC_W    = TRIG_BITS - 2;
    localparam int T_SHIFT   = 30 - FRAC_W;
    localparam int MEM_DEPTH = MAX_MODES * 16;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // configuration
    logic [8:0]         mode_count_reg;
    logic signed [31:0] force_scale_reg;
    logic               three_d_reg;

    // mode table, one word per address
    logic [31:0]        mem [MEM_DEPTH];
    logic [31:0]        rdata_reg;
    logic               fetch_d_reg;
    logic [3:0]         word_d_reg;
    logic [IDX_W+3:0]   waddr;
    logic [IDX_W+3:0]   raddr;
    logic               wr_ok;
    logic [31:0]        wval;

    // working registers
    logic signed [31:0] k_reg  [3];
    logic signed [31:0] cc_reg [3];
    logic signed [31:0] sc_reg [3];
    logic signed [31:0] amp_reg;
    logic [31:0]        px_reg, py_reg, pz_reg;
    logic               mass_reg;
    logic [31:0]        phase_reg;
    logic [30:0]        t2_reg;
    logic [31:0]        p_reg;
    logic [30:0]        st_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [63:0] ac_reg;
    logic signed [31:0] inner_reg;
    logic signed [63:0] acc_reg [3];
    logic signed [95:0] big_reg;
    logic signed [65:0] prod_reg;
    logic [31:0]        res_reg [3];

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next;
    logic [TRIG_BITS-1:0] idx;
    logic [1:0]         quad;
    logic [30:0]        t_base, teff;
    logic [32:0]        fin;
    logic [30:0]        fv;
    logic signed [31:0] fv_s, st_s;
    logic signed [63:0] ps64, diff;
    logic signed [95:0] total;
    logic signed [31:0] res_val;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        begin
            if (v > 96'sh7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -96'sh8000_0000)
                r = -32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    assign n_modes = (int'(mode_count_reg) > MAX_MODES) ? CNT_W'(MAX_MODES)
                                                        : CNT_W'(mode_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_count_reg  <= 9'd0;
            force_scale_reg <= 32'sd268435456;
            three_d_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE_COUNT:  mode_count_reg  <= cfg_data[8:0];
                CFG_FORCE_SCALE: force_scale_reg <= cfg_data;
                CFG_THREE_D:     three_d_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // table write, wavenumbers saturated to 16 bits
    always_comb
    begin
        wval = word_value;
        if (word_select <= WSEL_K_Z)
        begin
            if ($signed(word_value) > 32'sd32767)
                wval = 32'h0000_7FFF;
            else if ($signed(word_value) < -32'sd32768)
                wval = 32'hFFFF_8000;
        end
    end

    assign wr_ok = cmd.load && (int'(mode_slot) < MAX_MODES) && (word_select <= WSEL_SIN_Z);
    assign waddr = {IDX_W'(mode_slot), word_select};
    assign raddr = {mode_idx, cmd.fetch_word};

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem[waddr] <= wval;
        rdata_reg  <= mem[raddr];
        word_d_reg <= cmd.fetch_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fetch_d_reg <= 1'b0;
        else
            fetch_d_reg <= cmd.fetch;
    end

    // trig argument from the phase
    assign idx    = phase_reg[31 -: TRIG_BITS];
    assign quad   = idx[TRIG_BITS-1 -: 2];
    assign t_base = 31'(idx[FRAC_W-1:0]) << T_SHIFT;
    assign teff   = cmd.cos_pass ? (Q30_ONE - t_base) : t_base;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_KX:
            begin
                mul_a = {k_reg[0][31], k_reg[0]};
                mul_b = {1'b0, px_reg};
            end
            MUL_KY:
            begin
                mul_a = {k_reg[1][31], k_reg[1]};
                mul_b = {1'b0, py_reg};
            end
            MUL_KZ:
            begin
                mul_a = {k_reg[2][31], k_reg[2]};
                mul_b = {1'b0, pz_reg};
            end
            MUL_TT:
            begin
                mul_a = {2'b0, teff};
                mul_b = {2'b0, teff};
            end
            MUL_PT2:
            begin
                mul_a = {1'b0, p_reg};
                mul_b = {2'b0, t2_reg};
            end
            MUL_PT:
            begin
                mul_a = {1'b0, p_reg};
                mul_b = {2'b0, teff};
            end
            MUL_AC:
            begin
                mul_a = {cc_reg[cmd.axis][31], cc_reg[cmd.axis]};
                mul_b = {cos_reg[31], cos_reg};
            end
            MUL_BS:
            begin
                mul_a = {sc_reg[cmd.axis][31], sc_reg[cmd.axis]};
                mul_b = {sin_reg[31], sin_reg};
            end
            MUL_AI:
            begin
                mul_a = {amp_reg[31], amp_reg};
                mul_b = {inner_reg[31], inner_reg};
            end
            MUL_SLO:
            begin
                mul_a = {1'b0, acc_reg[cmd.axis][31:0]};
                mul_b = {force_scale_reg[31], force_scale_reg};
            end
            MUL_SHI:
            begin
                mul_a = {acc_reg[cmd.axis][63], acc_reg[cmd.axis][63:32]};
                mul_b = {force_scale_reg[31], force_scale_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // write-back helpers
    assign ps64  = $signed(prod_reg[63:0]);
    assign fin   = prod_reg[62:30];
    assign fv    = (fin > {2'b0, Q30_ONE}) ? Q30_ONE : fin[30:0];
    assign fv_s  = {1'b0, fv};
    assign st_s  = {1'b0, st_reg};
    assign diff  = ac_reg - ps64;
    assign total = big_reg + $signed({prod_reg[63:0], 32'b0});

    always_comb
    begin
        res_val = sat32(total >>> 28);
        if (!mass_reg || ((cmd.axis == 2'd2) && !three_d_reg))
            res_val = '0;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (fetch_d_reg)
        begin
            case (word_d_reg) inside
                [WSEL_K_X:WSEL_K_Z]:     k_reg[2'(word_d_reg - WSEL_K_X)] <= rdata_reg;
                WSEL_AMP:                amp_reg <= rdata_reg;
                [WSEL_COS_X:WSEL_COS_Z]: cc_reg[2'(word_d_reg - WSEL_COS_X)] <= rdata_reg;
                [WSEL_SIN_X:WSEL_SIN_Z]: sc_reg[2'(word_d_reg - WSEL_SIN_X)] <= rdata_reg;
                default:                 ;
            endcase
        end

        if (cmd.capture)
        begin
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pz_reg     <= pos_z;
            mass_reg   <= has_mass;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end

        case (cmd.wb)
            WB_PH_CLR: phase_reg <= prod_reg[31:0];
            WB_PH_ADD: phase_reg <= phase_reg + prod_reg[31:0];
            WB_T2:
            begin
                t2_reg <= prod_reg[60:30];
                p_reg  <= sin_poly(3'd6);
            end
            WB_HORN:   p_reg <= sin_poly(cmd.horn_idx) - prod_reg[61:30];
            WB_FIN:
            begin
                if (!cmd.cos_pass)
                    st_reg <= fv;
                else
                begin
                    case (quad)
                        2'd0:
                        begin
                            sin_reg <= st_s;
                            cos_reg <= fv_s;
                        end
                        2'd1:
                        begin
                            sin_reg <= fv_s;
                            cos_reg <= -st_s;
                        end
                        2'd2:
                        begin
                            sin_reg <= -st_s;
                            cos_reg <= -fv_s;
                        end
                        default:
                        begin
                            sin_reg <= -fv_s;
                            cos_reg <= st_s;
                        end
                    endcase
                end
            end
            WB_AC:     ac_reg <= ps64;
            WB_BS:     inner_reg <= sat32(96'(diff >>> 30));
            WB_ACC:    acc_reg[cmd.axis] <= acc_reg[cmd.axis] + (ps64 >>> 28);
            WB_SLO:    big_reg <= {{30{prod_reg[65]}}, prod_reg};
            WB_SHI:    res_reg[cmd.axis] <= res_val;
            default:   ;
        endcase
    end

    assign accel_x = res_reg[0];
    assign accel_y = res_reg[1];
    assign accel_z = res_reg[2];

endmodule
`default_nettype wire

// ===== hdl/fourier_forcing_evaluator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load item: no result.
// Evaluate item: per summed mode, 10 table reads and 28 multiplies of the shared 33x33 multiplier
// (each multiply followed by its write-back), plus setup and final scaling.
// One evaluate item is in work at a time; the next is taken once the result is held.
// Reset: configuration takes its reset values; the mode table is not cleared.
// ----------------------------------------------------------------------------
// fourier_forcing_evaluator_unit: Fourier-mode turbulence forcing evaluator
// Stores forcing modes and sums the forcing acceleration at a particle position.
// ----------------------------------------------------------------------------
module fourier_forcing_evaluator_unit #(
    parameter int MAX_MODES = ffe_pkg::MAX_MODES_DEF,
    parameter int TRIG_BITS = ffe_pkg::TRIG_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ffe_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [ffe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // mode_slot, word_select, word_value, pos_x, pos_y, pos_z, has_mass, pad
    input  wire logic [143:0]                   s_tdata,
    // command
    input  wire logic [0:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // accel_x, accel_y, accel_z
    output logic [95:0]                         m_tdata
);
    import ffe_pkg::*;

    localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CNT_W = $clog2(MAX_MODES + 1);

    dp_cmd_t          cmd;
    logic [IDX_W-1:0] mode_idx;
    logic [CNT_W-1:0] n_modes;
    logic [31:0]      accel_x, accel_y, accel_z;

    ffe_ctrl #(
        .MAX_MODES (MAX_MODES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_bit  (s_tuser[0]),
        .n_modes  (n_modes),
        .mode_idx (mode_idx),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    ffe_datapath #(
        .MAX_MODES (MAX_MODES),
        .TRIG_BITS (TRIG_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mode_slot   (s_tdata[7:0]),
        .word_select (s_tdata[11:8]),
        .word_value  (s_tdata[43:12]),
        .pos_x       (s_tdata[75:44]),
        .pos_y       (s_tdata[107:76]),
        .pos_z       (s_tdata[139:108]),
        .has_mass    (s_tdata[140]),
        .cmd         (cmd),
        .mode_idx    (mode_idx),
        .n_modes     (n_modes),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z)
    );

    assign m_tdata = {accel_z, accel_y, accel_x};

endmodule
`default_nettype wire

// ===== dv/tb_fourier_forcing_evaluator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fourier_forcing_evaluator_unit: self-checking bench of the forcing unit
// Loads mode table words and evaluates positions over a stream port, predicts
// each acceleration item from a local copy of the table and registers, and
// compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_fourier_forcing_evaluator_unit;

    import ffe_pkg::*;

    localparam int          NUM_MODES   = MAX_MODES_DEF;
    localparam int          WIDE_MODES  = 64;
    localparam int          PHASE_BITS  = TRIG_BITS_DEF;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          DRAIN_WAIT  = 40;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned SINE_COEF [7] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // mode_slot, word_select, word_value, pos_x, pos_y, pos_z, has_mass, pad
    logic [143:0]          s_tdata;
    // command
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // accel_x, accel_y, accel_z
    logic [95:0]           m_tdata;

    // local copy of the mode table and registers
    logic signed [31:0] wavenum   [NUM_MODES][3];
    logic signed [31:0] amplitude [NUM_MODES];
    logic signed [31:0] cos_coef  [NUM_MODES][3];
    logic signed [31:0] sin_coef  [NUM_MODES][3];
    logic [8:0]         active_modes;
    logic signed [31:0] scale_q28;
    logic               z_enabled;

    logic [95:0] accel_expected [$];
    int          mismatches;
    int          cycles;
    int          filled_modes;
    bit          quiet;
    bit          hold_req;

    fourier_forcing_evaluator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned quarter_wave(input longint unsigned t);
        longint unsigned t2;
        longint unsigned p;
        begin
            t2 = (t * t) >> 30;
            p  = SINE_COEF[6];
            for (int i = 5; i >= 0; i--)
                p = SINE_COEF[i] - ((p * t2) >> 30);
            p = (p * t) >> 30;
            if (p > ONE_Q30)
                p = ONE_Q30;
            return p;
        end
    endfunction

    function automatic void phase_trig(input logic [31:0] phase,
                                       output longint c, output longint s);
        logic [PHASE_BITS-1:0] idx;
        longint unsigned       t;
        longint                st;
        longint                sc;
        begin
            idx = phase[31 -: PHASE_BITS];
            t   = longint'(idx[PHASE_BITS-3:0]) << (30 - (PHASE_BITS - 2));
            st  = longint'(quarter_wave(t));
            sc  = longint'(quarter_wave(ONE_Q30 - t));
            case (idx[PHASE_BITS-1 -: 2])
                2'd0:    begin s = st;  c = sc;  end
                2'd1:    begin s = sc;  c = -st; end
                2'd2:    begin s = -st; c = -sc; end
                default: begin s = -sc; c = st;  end
            endcase
        end
    endfunction

    function automatic logic signed [31:0] sat_word(input logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'h7fffffff;
        if (x < -128'sd2147483648)
            return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic void store_word(input logic [7:0] slot, input logic [3:0] sel,
                                       input logic signed [31:0] val);
        logic signed [31:0] k;
        begin
            k = val;
            if (k > 32767)
                k = 32767;
            if (k < -32768)
                k = -32768;
            if (sel <= WSEL_K_Z)
                wavenum[slot][sel] = k;
            else if (sel == WSEL_AMP)
                amplitude[slot] = val;
            else if (sel <= WSEL_COS_Z)
                cos_coef[slot][sel - WSEL_COS_X] = val;
            else if (sel <= WSEL_SIN_Z)
                sin_coef[slot][sel - WSEL_SIN_X] = val;
            // higher selects are dropped
        end
    endfunction

    function automatic logic [95:0] forcing_accel(input logic [31:0] px, input logic [31:0] py,
                                                  input logic [31:0] pz, input logic mass);
        longint              acc [3];
        logic [31:0]         pos [3];
        logic [31:0]         phase;
        longint              c;
        longint              s;
        longint              d;
        longint              inner;
        int                  n;
        logic signed [31:0]  res [3];
        begin
            pos = '{px, py, pz};
            acc = '{0, 0, 0};
            n = (active_modes > NUM_MODES) ? NUM_MODES : active_modes;
            for (int m = 0; m < n; m++) begin
                phase = 0;
                for (int j = 0; j < 3; j++)
                    phase += wavenum[m][j] * pos[j];
                phase_trig(phase, c, s);
                for (int j = 0; j < 3; j++) begin
                    d = longint'(cos_coef[m][j]) * c - longint'(sin_coef[m][j]) * s;
                    inner = longint'(sat_word(128'(d >>> 30)));
                    acc[j] += (longint'(amplitude[m]) * inner) >>> 28;
                end
            end
            res = '{0, 0, 0};
            if (mass) begin
                for (int j = 0; j < 3; j++)
                    res[j] = sat_word((128'(signed'(acc[j])) * 128'(scale_q28)) >>> 28);
                if (!z_enabled)
                    res[2] = 0;
            end
            return {res[2], res[1], res[0]};
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus plumbing
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [7:0] slot, input logic [3:0] sel,
                             input logic [31:0] val, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic mass);
        begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            s_tuser  = cmd;
            s_tdata  = {3'b0, mass, pz, py, px, val, sel, slot};
            s_tvalid = 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (cmd == CMD_LOAD)
                store_word(slot, sel, val);
            else
                accel_expected.push_back(forcing_accel(px, py, pz, mass));
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic load_word(input logic [7:0] slot, input logic [3:0] sel,
                             input logic [31:0] val);
        send_item(CMD_LOAD, slot, sel, val, $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic evaluate(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic mass);
        send_item(CMD_EVAL, 8'($urandom), 4'($urandom), $urandom, px, py, pz, mass);
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_word(input logic [3:0] sel);
        if (sel <= WSEL_K_Z)
            return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32) - 16;
        return ($urandom_range(0, 5) == 0) ? $urandom : 32'($signed($urandom) >>> 2);
    endfunction

    task automatic wait_idle();
        while (accel_expected.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        begin
            cfg_we   = 1'b1;
            cfg_addr = idx;
            cfg_data = val;
            @(negedge clk);
            cfg_we = 1'b0;
            if (idx == CFG_MODE_COUNT)
                active_modes = val[8:0];
            else if (idx == CFG_FORCE_SCALE)
                scale_q28 = val;
            else if (idx == CFG_THREE_D)
                z_enabled = val[0];
        end
    endtask

    task automatic fill_modes(input int first, input int last);
        for (int m = first; m <= last; m++)
            for (int w = 0; w <= WSEL_SIN_Z; w++)
                load_word(8'(m), 4'(w), pick_word(4'(w)));
    endtask

    task automatic random_eval(input int max_count);
        begin
            wait_idle();
            write_reg(CFG_MODE_COUNT, $urandom_range(0, max_count));
            evaluate(pick_position(), pick_position(), pick_position(), $urandom_range(0, 7) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        // no modes summed at reset: zero force
        evaluate($urandom, $urandom, $urandom, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed();
        begin
            fill_modes(0, 15);
            filled_modes = 16;
            // wavenumbers beyond 16 bits saturate, amplitude and coefficients at extremes
            load_word(8'd0, WSEL_K_X, 32'h7fffffff);
            load_word(8'd0, WSEL_K_Z, 32'h80000000);
            load_word(8'd1, WSEL_AMP, 32'h7fffffff);
            load_word(8'd1, WSEL_COS_X, 32'h80000000);
            load_word(8'd1, WSEL_SIN_Z, 32'h7fffffff);
            load_word(8'd2, WSEL_AMP, 32'h80000000);
            // selects above the table words are dropped
            for (int w = WSEL_SIN_Z + 1; w < 16; w++)
                load_word(8'd0, 4'(w), $urandom);
            wait_idle();
            write_reg(CFG_MODE_COUNT, 3);
            evaluate(32'h0, 32'h0, 32'h0, 1'b1);
            evaluate(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
            evaluate($urandom, $urandom, $urandom, 1'b0);
            wait_idle();
            write_reg(CFG_THREE_D, 0);
            evaluate($urandom, $urandom, $urandom, 1'b1);
            wait_idle();
            write_reg(CFG_THREE_D, 1);
            write_reg(CFG_FORCE_SCALE, 32'h7fffffff);
            evaluate($urandom, $urandom, $urandom, 1'b1);
            wait_idle();
            write_reg(CFG_FORCE_SCALE, 32'h80000000);
            evaluate($urandom, $urandom, $urandom, 1'b1);
            wait_idle();
            write_reg(CFG_FORCE_SCALE, 32'h0);
            evaluate($urandom, $urandom, $urandom, 1'b1);
            wait_idle();
            write_reg(CFG_FORCE_SCALE, 32'h10000000);
        end
    endtask

    task automatic test_full_table();
        begin
            // widen the written range and sum all of it
            fill_modes(16, WIDE_MODES - 1);
            filled_modes = WIDE_MODES;
            wait_idle();
            write_reg(CFG_MODE_COUNT, WIDE_MODES);
            evaluate(pick_position(), pick_position(), pick_position(), 1'b1);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        begin
            write_reg(CFG_MODE_COUNT, 2);
            hold_req = 1'b1;
            for (int i = 0; i < 12; i++)
                evaluate(pick_position(), pick_position(), pick_position(), 1'b1);
            // pause until every result is back
            wait_idle();
        end
    endtask

    task automatic test_random(input int items);
        int done;
        int slot;
        int w;
        begin
            done = 0;
            while (done < items) begin
                if ($urandom_range(0, 59) == 0) begin
                    wait_idle();
                    case ($urandom_range(0, 4))
                        0:       write_reg(CFG_FORCE_SCALE, 32'h7fffffff);
                        1:       write_reg(CFG_FORCE_SCALE, 32'h80000000);
                        2:       write_reg(CFG_FORCE_SCALE, 32'h10000000);
                        default: write_reg(CFG_FORCE_SCALE, $urandom);
                    endcase
                    write_reg(CFG_THREE_D, $urandom_range(0, 1));
                end
                if ($urandom_range(0, 2) == 0) begin
                    // mostly keep a short active range so evaluates stay quick
                    if ($urandom_range(0, 99) == 0)
                        random_eval(filled_modes);
                    else if ($urandom_range(0, 3) == 0)
                        random_eval(12);
                    else
                        evaluate(pick_position(), pick_position(), pick_position(),
                                 $urandom_range(0, 7) != 0);
                end else begin
                    slot = $urandom_range(0, 9) == 0 ? $urandom_range(0, NUM_MODES - 1)
                                                     : $urandom_range(0, 15);
                    w = $urandom_range(0, 15);
                    load_word(8'(slot), 4'(w), pick_word(4'(w)));
                end
                done++;
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // result sink: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end else begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (accel_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                logic [95:0] want;
                want = accel_expected.pop_front();
                for (int j = 0; j < 3; j++)
                    if (m_tdata[32*j +: 32] !== want[32*j +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("accel axis %0d: expected %h, got %h",
                                     j, want[32*j +: 32], m_tdata[32*j +: 32]);
                    end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        filled_modes = 0;
        active_modes = 0;
        scale_q28 = 32'h10000000;
        z_enabled = 1'b1;
        for (int m = 0; m < NUM_MODES; m++) begin
            amplitude[m] = 0;
            for (int j = 0; j < 3; j++) begin
                wavenum[m][j] = 0;
                cos_coef[m][j] = 0;
                sin_coef[m][j] = 0;
            end
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(1000);
        quiet = 1'b1;
        test_random(175);

        repeat (100) @(negedge clk);
        if (mismatches == 0 && accel_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== fourier_forcing_evaluator_unit.f =====
hdl/ffe_pkg.sv
hdl/ffe_ctrl.sv
hdl/ffe_datapath.sv
hdl/fourier_forcing_evaluator_unit.sv
dv/tb_fourier_forcing_evaluator_unit.sv
